// ----- rtl/sit_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse index table package
// Table geometry, command and status codes, and the control and status
// bundles that pass between the sequencer and the datapath.
// ----------------------------------------------------------------------------
package sit_pkg;

    localparam int NUM_BLOCKS  = 32;
    localparam int BLOCK_SIZE  = 32;
    localparam int HANDLE_BITS = 16;

    localparam int TABLE_SIZE = NUM_BLOCKS * BLOCK_SIZE;
    localparam int IDX_W      = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
    localparam int DATA_W     = HANDLE_BITS + 1;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

    // Fixed port widths.
    localparam int CMD_W    = 3;
    localparam int POS_W    = 10;
    localparam int HANDLE_W = 16;
    localparam int STATUS_W = 2;

    localparam logic [CMD_W-1:0] CMD_LOOKUP = 3'd0;
    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_OPEN   = 3'd3;
    localparam logic [CMD_W-1:0] CMD_CLOSE  = 3'd4;
    localparam logic [CMD_W-1:0] CMD_NEXT   = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_RANGE   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BLOCKED = 2'd3;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_LAST,
        RD_PTR
    } t_rd_sel;

    typedef enum logic [2:0] {
        PTR_HOLD,
        PTR_POS_UP,
        PTR_LAST_DN,
        PTR_UP,
        PTR_DOWN
    } t_ptr_op;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_INS,
        WR_ZERO_PTR,
        WR_ZERO_POS,
        WR_ZERO_LAST,
        WR_SHIFT_UP,
        WR_SHIFT_DN
    } t_wr_sel;

    typedef enum logic [2:0] {
        RES_NONE,
        RES_OK,
        RES_RANGE,
        RES_EMPTY,
        RES_BLOCKED,
        RES_HIT_LOOK,
        RES_HIT_NEXT
    } t_res_sel;

    typedef struct packed {
        logic     latch;
        t_rd_sel  rd_sel;
        t_ptr_op  ptr_op;
        t_wr_sel  wr_sel;
        t_res_sel res_sel;
    } t_dp_ctl;

    typedef struct packed {
        logic [CMD_W-1:0] cmd;
        logic             in_range;
        logic             pos_is_last;
        logic             ptr_is_last;
        logic             ptr_is_pos;
        logic             pend;
        logic             rd_valid;
        logic             out_free;
    } t_dp_sts;

endpackage
`default_nettype wire

// ----- rtl/sit_ram.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with a registered read that holds its
// data while no read is issued.
// ----------------------------------------------------------------------------
module sit_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                                         i_clk,
    input  wire logic                                         i_wr_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]                             i_wr_data,
    input  wire logic                                         i_rd_en,
    input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]                             o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule
`default_nettype wire

// ----- rtl/sit_dp.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse index table datapath
// Holds the command registers, the walk pointer, the entry RAM and the
// result register, and carries out what the sequencer selects each cycle.
// ----------------------------------------------------------------------------
module sit_dp (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic [sit_pkg::CMD_W-1:0]      i_cmd,
    input  wire logic [sit_pkg::POS_W-1:0]      i_position,
    input  wire logic [sit_pkg::HANDLE_W-1:0]   i_handle_in,
    input  wire sit_pkg::t_dp_ctl               i_ctl,
    output sit_pkg::t_dp_sts                    o_sts,
    input  wire logic                           i_ready,
    output logic                                o_valid,
    output logic      [sit_pkg::STATUS_W-1:0]   o_status,
    output logic      [sit_pkg::HANDLE_W-1:0]   o_handle_out,
    output logic      [sit_pkg::POS_W-1:0]      o_position_out
);
    import sit_pkg::*;

    logic [CMD_W-1:0]       r_cmd;
    logic [IDX_W-1:0]       r_pos;
    logic [HANDLE_BITS-1:0] r_hin;
    logic                   r_in_range;

    logic [IDX_W-1:0] r_ptr;
    logic [IDX_W-1:0] n_ptr;
    logic [IDX_W-1:0] r_ptr_d;
    logic             r_pend;

    logic              wr_en;
    logic [IDX_W-1:0]  wr_addr;
    logic [DATA_W-1:0] wr_data;
    logic              rd_en;
    logic [IDX_W-1:0]  rd_addr;
    logic [DATA_W-1:0] rd_data;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_status;
    logic [HANDLE_W-1:0] r_handle_out;
    logic [POS_W-1:0]    r_pos_out;
    logic                out_free;

    logic [STATUS_W-1:0] n_status;
    logic [HANDLE_W-1:0] n_handle_out;
    logic [POS_W-1:0]    n_pos_out;

    // Command registers, loaded on the input transfer.
    always_ff @(posedge i_clk) begin
        if (i_ctl.latch) begin
            r_cmd      <= i_cmd;
            r_pos      <= IDX_W'(i_position);
            r_hin      <= HANDLE_BITS'(i_handle_in);
            r_in_range <= (32'(i_position) < TABLE_SIZE);
        end
    end

    always_comb begin
        case (i_ctl.ptr_op)
            PTR_POS_UP:  n_ptr = r_pos + 1'b1;
            PTR_LAST_DN: n_ptr = LAST_IDX - 1'b1;
            PTR_UP:      n_ptr = r_ptr + 1'b1;
            PTR_DOWN:    n_ptr = r_ptr - 1'b1;
            default:     n_ptr = r_ptr;
        endcase
    end

    // The pointer starts at zero so that it sweeps the clearing pass.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr  <= '0;
            r_pend <= 1'b0;
        end else begin
            r_ptr  <= n_ptr;
            r_pend <= rd_en;
        end
    end

    always_comb begin
        rd_en = 1'b1;
        case (i_ctl.rd_sel)
            RD_POS:  rd_addr = r_pos;
            RD_LAST: rd_addr = LAST_IDX;
            RD_PTR:  rd_addr = r_ptr;
            default: begin
                rd_en   = 1'b0;
                rd_addr = r_ptr;
            end
        endcase
    end

    // r_ptr_d names the entry whose word sits on the RAM output.
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_ptr_d <= rd_addr;
        end
    end

    always_comb begin
        wr_en   = 1'b1;
        wr_addr = r_pos;
        wr_data = '0;
        case (i_ctl.wr_sel)
            WR_INS:       wr_data = {1'b1, r_hin};
            WR_ZERO_PTR:  wr_addr = r_ptr;
            WR_ZERO_POS:  wr_addr = r_pos;
            WR_ZERO_LAST: wr_addr = LAST_IDX;
            WR_SHIFT_UP: begin
                wr_addr = r_ptr_d + 1'b1;
                wr_data = rd_data;
            end
            WR_SHIFT_DN: begin
                wr_addr = r_ptr_d - 1'b1;
                wr_data = rd_data;
            end
            default:      wr_en = 1'b0;
        endcase
    end

    sit_ram #(
        .WIDTH (DATA_W),
        .DEPTH (TABLE_SIZE)
    ) u_entry_ram (
        .i_clk     (i_clk),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data)
    );

    always_comb begin
        n_status     = ST_OK;
        n_handle_out = '0;
        n_pos_out    = '0;
        case (i_ctl.res_sel)
            RES_RANGE:    n_status = ST_RANGE;
            RES_EMPTY:    n_status = ST_EMPTY;
            RES_BLOCKED:  n_status = ST_BLOCKED;
            RES_HIT_LOOK: n_handle_out = HANDLE_W'(rd_data[HANDLE_BITS-1:0]);
            RES_HIT_NEXT: begin
                n_handle_out = HANDLE_W'(rd_data[HANDLE_BITS-1:0]);
                n_pos_out    = POS_W'(r_ptr_d);
            end
            default:      n_status = ST_OK;
        endcase
    end

    assign out_free = !r_out_valid || i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctl.res_sel != RES_NONE) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.res_sel != RES_NONE) begin
            r_status     <= n_status;
            r_handle_out <= n_handle_out;
            r_pos_out    <= n_pos_out;
        end
    end

    assign o_sts.cmd         = r_cmd;
    assign o_sts.in_range    = r_in_range;
    assign o_sts.pos_is_last = (r_pos == LAST_IDX);
    assign o_sts.ptr_is_last = (r_ptr == LAST_IDX);
    assign o_sts.ptr_is_pos  = (r_ptr == r_pos);
    assign o_sts.pend        = r_pend;
    assign o_sts.rd_valid    = rd_data[DATA_W-1];
    assign o_sts.out_free    = out_free;

    assign o_valid        = r_out_valid;
    assign o_status       = r_status;
    assign o_handle_out   = r_handle_out;
    assign o_position_out = r_pos_out;

    // A shift never writes the entry that is being read in the same cycle.
    a_no_rw_collision: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (wr_en && rd_en) |-> (wr_addr != rd_addr))
        else $error("entry RAM read and write hit the same address");

    // A shifted word must come from a read issued in the previous cycle.
    a_shift_has_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.wr_sel == WR_SHIFT_UP || i_ctl.wr_sel == WR_SHIFT_DN) |-> r_pend)
        else $error("shift writes without a pending read");

    // A result is loaded only when the output register can take it.
    a_res_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_ctl.res_sel != RES_NONE) |-> out_free)
        else $error("result loaded over an untaken result");

endmodule
`default_nettype wire

// ----- rtl/sit_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse index table sequencer
// Runs the clearing pass after reset, decodes each command and steps the
// datapath through reads, shifts and scans one table entry per cycle.
// ----------------------------------------------------------------------------
module sit_ctrl (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_valid,
    output logic                   o_ready,
    input  wire sit_pkg::t_dp_sts  i_sts,
    output sit_pkg::t_dp_ctl       o_ctl
);
    import sit_pkg::*;

    typedef enum logic [14:0] {
        S_CLEAR    = 15'b000000000000001,
        S_IDLE     = 15'b000000000000010,
        S_START    = 15'b000000000000100,
        S_LK_EVAL  = 15'b000000000001000,
        S_OP_CHK   = 15'b000000000010000,
        S_OP_WALK  = 15'b000000000100000,
        S_OP_TAIL  = 15'b000000001000000,
        S_FIN_POS  = 15'b000000010000000,
        S_CL_WALK  = 15'b000000100000000,
        S_CL_TAIL  = 15'b000001000000000,
        S_FIN_LAST = 15'b000010000000000,
        S_NX_WALK  = 15'b000100000000000,
        S_NX_LAST  = 15'b001000000000000,
        S_NX_HIT   = 15'b010000000000000,
        S_NX_MISS  = 15'b100000000000000
    } t_state;

    t_state  r_state;
    t_state  n_state;
    t_dp_ctl ctl;
    logic    accept;

    assign o_ready = (r_state == S_IDLE);
    assign accept  = i_valid && o_ready;

    always_comb begin
        n_state     = r_state;
        ctl.latch   = accept;
        ctl.rd_sel  = RD_NONE;
        ctl.ptr_op  = PTR_HOLD;
        ctl.wr_sel  = WR_NONE;
        ctl.res_sel = RES_NONE;
        case (r_state)
            S_CLEAR: begin
                ctl.wr_sel = WR_ZERO_PTR;
                ctl.ptr_op = PTR_UP;
                if (i_sts.ptr_is_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_START;
                end
            end
            S_START: begin
                if (!(i_sts.cmd inside {[CMD_LOOKUP:CMD_NEXT]})) begin
                    if (i_sts.out_free) begin
                        ctl.res_sel = RES_OK;
                        n_state     = S_IDLE;
                    end
                end else if (!i_sts.in_range) begin
                    if (i_sts.out_free) begin
                        ctl.res_sel = RES_RANGE;
                        n_state     = S_IDLE;
                    end
                end else begin
                    case (i_sts.cmd)
                        CMD_LOOKUP: begin
                            ctl.rd_sel = RD_POS;
                            n_state    = S_LK_EVAL;
                        end
                        CMD_INSERT: begin
                            if (i_sts.out_free) begin
                                ctl.wr_sel  = WR_INS;
                                ctl.res_sel = RES_OK;
                                n_state     = S_IDLE;
                            end
                        end
                        CMD_REMOVE: begin
                            if (i_sts.out_free) begin
                                ctl.wr_sel  = WR_ZERO_POS;
                                ctl.res_sel = RES_OK;
                                n_state     = S_IDLE;
                            end
                        end
                        CMD_OPEN: begin
                            ctl.rd_sel = RD_LAST;
                            n_state    = S_OP_CHK;
                        end
                        CMD_CLOSE: begin
                            if (i_sts.pos_is_last) begin
                                n_state = S_FIN_LAST;
                            end else begin
                                ctl.ptr_op = PTR_POS_UP;
                                n_state    = S_CL_WALK;
                            end
                        end
                        default: begin
                            // Next occupied: nothing lies above the last entry.
                            if (i_sts.pos_is_last) begin
                                n_state = S_NX_MISS;
                            end else begin
                                ctl.ptr_op = PTR_POS_UP;
                                n_state    = S_NX_WALK;
                            end
                        end
                    endcase
                end
            end
            S_LK_EVAL: begin
                if (i_sts.out_free) begin
                    ctl.res_sel = i_sts.rd_valid ? RES_HIT_LOOK : RES_EMPTY;
                    n_state     = S_IDLE;
                end
            end
            S_OP_CHK: begin
                if (i_sts.rd_valid) begin
                    if (i_sts.out_free) begin
                        ctl.res_sel = RES_BLOCKED;
                        n_state     = S_IDLE;
                    end
                end else if (i_sts.pos_is_last) begin
                    n_state = S_FIN_POS;
                end else begin
                    ctl.ptr_op = PTR_LAST_DN;
                    n_state    = S_OP_WALK;
                end
            end
            S_OP_WALK: begin
                // Read one entry downward while the previous one moves up.
                ctl.wr_sel = i_sts.pend ? WR_SHIFT_UP : WR_NONE;
                ctl.rd_sel = RD_PTR;
                ctl.ptr_op = PTR_DOWN;
                if (i_sts.ptr_is_pos) begin
                    n_state = S_OP_TAIL;
                end
            end
            S_OP_TAIL: begin
                ctl.wr_sel = WR_SHIFT_UP;
                n_state    = S_FIN_POS;
            end
            S_FIN_POS: begin
                if (i_sts.out_free) begin
                    ctl.wr_sel  = WR_ZERO_POS;
                    ctl.res_sel = RES_OK;
                    n_state     = S_IDLE;
                end
            end
            S_CL_WALK: begin
                ctl.wr_sel = i_sts.pend ? WR_SHIFT_DN : WR_NONE;
                ctl.rd_sel = RD_PTR;
                ctl.ptr_op = PTR_UP;
                if (i_sts.ptr_is_last) begin
                    n_state = S_CL_TAIL;
                end
            end
            S_CL_TAIL: begin
                ctl.wr_sel = WR_SHIFT_DN;
                n_state    = S_FIN_LAST;
            end
            S_FIN_LAST: begin
                if (i_sts.out_free) begin
                    ctl.wr_sel  = WR_ZERO_LAST;
                    ctl.res_sel = RES_OK;
                    n_state     = S_IDLE;
                end
            end
            S_NX_WALK: begin
                // Stop reading on a hit so the found word stays on the RAM output.
                if (i_sts.pend && i_sts.rd_valid) begin
                    n_state = S_NX_HIT;
                end else begin
                    ctl.rd_sel = RD_PTR;
                    ctl.ptr_op = PTR_UP;
                    if (i_sts.ptr_is_last) begin
                        n_state = S_NX_LAST;
                    end
                end
            end
            S_NX_LAST: begin
                n_state = i_sts.rd_valid ? S_NX_HIT : S_NX_MISS;
            end
            S_NX_HIT: begin
                if (i_sts.out_free) begin
                    ctl.res_sel = RES_HIT_NEXT;
                    n_state     = S_IDLE;
                end
            end
            S_NX_MISS: begin
                if (i_sts.out_free) begin
                    ctl.res_sel = RES_EMPTY;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_ctl = ctl;

    a_accept_starts: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state == S_START))
        else $error("accepted command did not start");

    // The last entry of a scan is evaluated only from a read just issued.
    a_nx_last_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_NX_LAST) |-> i_sts.pend)
        else $error("scan end without read data");

    a_walk_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OP_WALK || r_state == S_CL_WALK || r_state == S_CLEAR)
            |-> (ctl.res_sel == RES_NONE))
        else $error("result issued in the middle of a walk");

endmodule
`default_nettype wire

// ----- rtl/sparse_index_table_with_shift.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// Sparse index table with shift
// Position-indexed handle table with lookup, insert, remove, open gap,
// close gap and next-occupied commands, one result per command.
// ----------------------------------------------------------------------------
//  Channel  Direction  Handshake           Payload
//  command  in         i_valid / o_ready   i_cmd, i_position, i_handle_in
//  result   out        o_valid / i_ready   o_status, o_handle_out, o_position_out
//
//  One command at a time; insert and remove write one entry, lookup reads one.
//  Open gap, close gap and next occupied walk the entries between the position
//  and the last entry; the single entry RAM moves one entry per cycle through
//  its read and write ports.
//  After reset a clearing pass writes every entry, TABLE_SIZE (1024) of them,
//  before the first command transfer is taken.
//  A command may be taken while the previous result waits; its result is
//  held back until the result register is free.
// ----------------------------------------------------------------------------
module sparse_index_table_with_shift (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_valid,
    output logic                                 o_ready,
    input  wire logic [sit_pkg::CMD_W-1:0]       i_cmd,
    input  wire logic [sit_pkg::POS_W-1:0]       i_position,
    input  wire logic [sit_pkg::HANDLE_W-1:0]    i_handle_in,
    output logic                                 o_valid,
    input  wire logic                            i_ready,
    output logic      [sit_pkg::STATUS_W-1:0]    o_status,
    output logic      [sit_pkg::HANDLE_W-1:0]    o_handle_out,
    output logic      [sit_pkg::POS_W-1:0]       o_position_out
);
    import sit_pkg::*;

    t_dp_ctl ctl;
    t_dp_sts sts;

    sit_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_ready (o_ready),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    sit_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (i_cmd),
        .i_position     (i_position),
        .i_handle_in    (i_handle_in),
        .i_ctl          (ctl),
        .o_sts          (sts),
        .i_ready        (i_ready),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_handle_out   (o_handle_out),
        .o_position_out (o_position_out)
    );

endmodule
`default_nettype wire
